// ===== hdl/sise_pkg.sv =====
// Shared types, codes and defaults of the sorted interval set engine.
package sise_pkg;

  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned TimeBitsDef  = 16;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_COVERS = 2'd1,
    ACT_SPLIT  = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_ld_cm1;
    logic    init_add;
    logic    set_split;
    logic    absorb;
    logic    set_j;
    logic    mv_write;
    logic    ins_write;
    logic    cut_write;
    logic    cnt_ld_n;
    logic    cnt_clr;
    logic    res_ld;
    status_e res_st;
    logic    res_cov;
    logic    emit_single;
    logic    emit_range;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    act_e act;
    logic idx_eq_cnt;
    logic idx_eq_cnt_m1;
    logic idx_eq_i;
    logic idx_gt_i1;
    logic end_le_a;
    logic a_in_range;
    logic b_lt_a;
    logic b_eq_a;
    logic in_rng;
    logic absorb_ok;
    logic full;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/sise_ctrl.sv =====
// Sequencing state machine of the sorted interval set engine.
module sise_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sise_pkg::stat_t stat_i,
  output sise_pkg::cmd_t  cmd_o
);
  import sise_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_DISP = 20'h00002,
    S_A_FI = 20'h00004,
    S_A_EI = 20'h00008,
    S_A_PI = 20'h00010,
    S_A_FJ = 20'h00020,
    S_A_EJ = 20'h00040,
    S_A_CN = 20'h00080,
    S_SHFD = 20'h00100,
    S_SHWD = 20'h00200,
    S_SHFU = 20'h00400,
    S_SHWU = 20'h00800,
    S_A_WR = 20'h01000,
    S_C_F  = 20'h02000,
    S_C_E  = 20'h04000,
    S_P_FK = 20'h08000,
    S_P_EK = 20'h10000,
    S_P_EM = 20'h20000,
    S_P_FM = 20'h40000,
    S_DONE = 20'h80000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.act)
          ACT_ADD: begin
            if (stat_i.b_lt_a) begin
              cmd_o.res_ld = 1'b1;
              cmd_o.res_st = ST_ORDER;
              state_d      = S_DONE;
            end else begin
              state_d = S_A_FI;
            end
          end
          ACT_COVERS: state_d = S_C_F;
          ACT_SPLIT:  state_d = S_P_FK;
          default: begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.res_ld  = 1'b1;
            state_d       = S_DONE;
          end
        endcase
      end
      S_A_FI: begin
        if (stat_i.idx_eq_cnt) begin
          cmd_o.init_add = 1'b1;
          state_d        = S_A_PI;
        end else begin
          state_d = S_A_EI;
        end
      end
      S_A_EI: begin
        if (stat_i.end_le_a) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_A_FI;
        end else begin
          cmd_o.init_add = 1'b1;
          state_d        = S_A_PI;
        end
      end
      S_A_PI: begin
        if (!stat_i.in_rng && stat_i.b_eq_a) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_A_FJ;
        end
      end
      S_A_FJ: state_d = stat_i.idx_eq_cnt ? S_A_CN : S_A_EJ;
      S_A_EJ: begin
        if (stat_i.absorb_ok) begin
          cmd_o.absorb  = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d       = S_A_FJ;
        end else begin
          state_d = S_A_CN;
        end
      end
      S_A_CN: begin
        cmd_o.set_j = 1'b1;
        if (stat_i.full) begin
          cmd_o.res_ld = 1'b1;
          cmd_o.res_st = ST_FULL;
          state_d      = S_DONE;
        end else if (stat_i.idx_eq_i && !stat_i.idx_eq_cnt) begin
          // new range goes in front of the tail: open a slot, top entry first
          cmd_o.idx_ld_cm1 = 1'b1;
          state_d          = S_SHFD;
        end else if (stat_i.idx_gt_i1 && !stat_i.idx_eq_cnt) begin
          state_d = S_SHFU;
        end else begin
          state_d = S_A_WR;
        end
      end
      S_SHFD: state_d = S_SHWD;
      S_SHWD: begin
        cmd_o.mv_write = 1'b1;
        if (stat_i.idx_eq_i) begin
          state_d = S_A_WR;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_SHFD;
        end
      end
      S_SHFU: state_d = S_SHWU;
      S_SHWU: begin
        cmd_o.mv_write = 1'b1;
        if (stat_i.idx_eq_cnt_m1) begin
          state_d = S_A_WR;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SHFU;
        end
      end
      S_A_WR: begin
        cmd_o.ins_write = 1'b1;
        cmd_o.cnt_ld_n  = 1'b1;
        cmd_o.res_ld    = 1'b1;
        state_d         = S_DONE;
      end
      S_C_F: begin
        if (stat_i.idx_eq_cnt) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_C_E;
        end
      end
      S_C_E: begin
        if (stat_i.a_in_range) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_cov = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_C_F;
        end
      end
      S_P_FK: begin
        if (stat_i.idx_eq_cnt) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_DONE;
        end else begin
          state_d = S_P_EK;
        end
      end
      S_P_EK: begin
        if (stat_i.end_le_a) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_P_FK;
        end else begin
          cmd_o.set_split = 1'b1;
          state_d         = S_P_EM;
        end
      end
      S_P_EM: begin
        if (stat_i.out_free) begin
          cmd_o.emit_range = 1'b1;
          cmd_o.cut_write  = stat_i.idx_eq_i && stat_i.in_rng;
          if (stat_i.idx_eq_cnt_m1) begin
            cmd_o.cnt_ld_n = 1'b1;
            state_d        = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_P_FM;
          end
        end
      end
      S_P_FM: state_d = S_P_EM;
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/sise_dp.sv =====
// Datapath of the sorted interval set engine: range memory, scan registers, result register.
module sise_dp #(
  parameter int unsigned MAX_RANGES = sise_pkg::MaxRangesDef,
  parameter int unsigned TIME_BITS  = sise_pkg::TimeBitsDef,
  localparam int unsigned AW = $clog2(MAX_RANGES),
  localparam int unsigned CW = $clog2(MAX_RANGES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sise_pkg::cmd_t       cmd_i,
  output sise_pkg::stat_t      stat_o,
  input  logic [1:0]           action_i,
  input  logic [TIME_BITS-1:0] time_a_i,
  input  logic [TIME_BITS-1:0] time_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 covered_o,
  output logic                 range_valid_o,
  output logic [TIME_BITS-1:0] range_start_o,
  output logic [TIME_BITS-1:0] range_end_o,
  output logic                 last_o,
  output logic [1:0]           status_o,
  output logic [CW-1:0]        range_count_o
);
  import sise_pkg::*;

  localparam int unsigned TW = TIME_BITS;

  logic [2*TW-1:0] mem_q [MAX_RANGES];
  logic [2*TW-1:0] rd_q;

  logic [1:0]    act_q;
  logic [TW-1:0] a_q, b_q, lo_q, hi_q;
  logic [CW-1:0] cnt_q, idx_q, i_q, j_q, n_q;
  logic          within_q;
  status_e       res_st_q;
  logic          res_cov_q;

  logic          out_valid_q, cov_oq, rv_oq, last_oq;
  logic [TW-1:0] rs_oq, re_oq;
  logic [1:0]    st_oq;
  logic [CW-1:0] rc_oq;

  logic [TW-1:0] rd_start, rd_end;
  logic [CW:0]   idx_p1, n_add, dest;
  logic          idx_eq_i, start_le_a, start_lt_a, out_free;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [2*TW-1:0] wr_data;

  assign rd_start = rd_q[2*TW-1:TW];
  assign rd_end   = rd_q[TW-1:0];

  assign idx_p1   = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
  assign n_add    = {1'b0, cnt_q} + {1'b0, i_q} + {{CW{1'b0}}, 1'b1} - {1'b0, idx_q};
  assign dest     = {1'b0, idx_q} + {1'b0, i_q} + {{CW{1'b0}}, 1'b1} - {1'b0, j_q};
  assign idx_eq_i = (idx_q == i_q);
  assign start_le_a = (rd_start <= a_q);
  assign start_lt_a = (rd_start < a_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.act           = act_e'(act_q);
    stat_o.idx_eq_cnt    = (idx_q == cnt_q);
    stat_o.idx_eq_cnt_m1 = (idx_p1 == {1'b0, cnt_q});
    stat_o.idx_eq_i      = idx_eq_i;
    stat_o.idx_gt_i1     = ({1'b0, idx_q} > ({1'b0, i_q} + {{CW{1'b0}}, 1'b1}));
    stat_o.end_le_a      = (rd_end <= a_q);
    stat_o.a_in_range    = start_le_a && (a_q < rd_end);
    stat_o.b_lt_a        = (b_q < a_q);
    stat_o.b_eq_a        = (b_q == a_q);
    stat_o.in_rng        = within_q;
    stat_o.absorb_ok     = (rd_start < b_q) || (idx_eq_i && within_q);
    stat_o.full          = (n_add > (CW+1)'(MAX_RANGES));
    stat_o.out_free      = out_free;
  end

  // one write port, chosen by the command
  always_comb begin
    wr_en   = cmd_i.mv_write || cmd_i.ins_write || cmd_i.cut_write;
    wr_addr = i_q[AW-1:0];
    wr_data = {lo_q, hi_q};
    if (cmd_i.mv_write) begin
      wr_addr = dest[AW-1:0];
      wr_data = rd_q;
    end else if (cmd_i.cut_write) begin
      wr_data = {rd_start, a_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_ld_n) begin
        cnt_q <= n_q;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_p1[CW-1:0];
      end else if (cmd_i.idx_dec) begin
        idx_q <= idx_q - {{(CW-1){1'b0}}, 1'b1};
      end else if (cmd_i.idx_ld_cm1) begin
        idx_q <= cnt_q - {{(CW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.emit_single || cmd_i.emit_range) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      a_q   <= time_a_i;
      b_q   <= time_b_i;
    end
    if (cmd_i.init_add) begin
      i_q      <= idx_q;
      within_q <= !(idx_q == cnt_q) && start_le_a;
      lo_q     <= (!(idx_q == cnt_q) && start_le_a) ? rd_start : a_q;
      hi_q     <= b_q;
    end
    if (cmd_i.set_split) begin
      i_q      <= idx_q;
      within_q <= start_lt_a;
      n_q      <= start_lt_a ? idx_p1[CW-1:0] : idx_q;
    end
    if (cmd_i.absorb && (rd_end > hi_q)) begin
      hi_q <= rd_end;
    end
    if (cmd_i.set_j) begin
      j_q <= idx_q;
      n_q <= n_add[CW-1:0];
    end
    if (cmd_i.res_ld) begin
      res_st_q  <= cmd_i.res_st;
      res_cov_q <= cmd_i.res_cov;
    end
    if (cmd_i.emit_single) begin
      cov_oq  <= res_cov_q;
      rv_oq   <= 1'b0;
      rs_oq   <= '0;
      re_oq   <= '0;
      last_oq <= 1'b1;
      st_oq   <= res_st_q;
      rc_oq   <= cnt_q;
    end else if (cmd_i.emit_range) begin
      cov_oq  <= 1'b0;
      rv_oq   <= 1'b1;
      rs_oq   <= (idx_eq_i && within_q) ? a_q : rd_start;
      re_oq   <= rd_end;
      last_oq <= (idx_p1 == {1'b0, cnt_q});
      st_oq   <= ST_OK;
      rc_oq   <= n_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign covered_o     = cov_oq;
  assign range_valid_o = rv_oq;
  assign range_start_o = rs_oq;
  assign range_end_o   = re_oq;
  assign last_o        = last_oq;
  assign status_o      = st_oq;
  assign range_count_o = rc_oq;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RANGES))
    else $error("range count above capacity");

  a_wr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ({1'b0, wr_addr} < (AW+1)'(MAX_RANGES)))
    else $error("memory write outside table");

  a_emit_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_range |-> (idx_q < cnt_q))
    else $error("split beat from beyond the list");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(cmd_i.emit_single || cmd_i.emit_range))
    else $error("result register overwritten before taken");

endmodule

// ===== hdl/sorted_interval_set_engine.sv =====
// Top level of the sorted interval set engine: controller plus datapath.
// Covers scans ranges in order; add passes, absorbs or moves ranges; split passes ranges,
// then emits the remaining ranges one beat each. Clear needs no scan.
// One operation at a time; the receiver can stall the results.
// Reset empties the list and drops any pending result; range memory is not cleared.
module sorted_interval_set_engine #(
  parameter int unsigned MAX_RANGES = sise_pkg::MaxRangesDef,
  parameter int unsigned TIME_BITS  = sise_pkg::TimeBitsDef,
  localparam int unsigned CW = $clog2(MAX_RANGES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           action_i,
  input  logic [TIME_BITS-1:0] time_a_i,
  input  logic [TIME_BITS-1:0] time_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 covered_o,
  output logic                 range_valid_o,
  output logic [TIME_BITS-1:0] range_start_o,
  output logic [TIME_BITS-1:0] range_end_o,
  output logic                 last_o,
  output logic [1:0]           status_o,
  output logic [CW-1:0]        range_count_o
);
  import sise_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sise_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sise_dp #(
    .MAX_RANGES (MAX_RANGES),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .time_a_i      (time_a_i),
    .time_b_i      (time_b_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .covered_o     (covered_o),
    .range_valid_o (range_valid_o),
    .range_start_o (range_start_o),
    .range_end_o   (range_end_o),
    .last_o        (last_o),
    .status_o      (status_o),
    .range_count_o (range_count_o)
  );

endmodule
